/* hdl/tvr_pkg.sv */
// ----------------------------------------------------------------------------
// tvr_pkg: shared types and constants for the three-axis velocity ramp
// Fixed-point formats, per-axis tuning constants, lane control structs and
// the move-toward-zero helper used by every axis lane.
// ----------------------------------------------------------------------------
`default_nettype none

package tvr_pkg;

   // field widths
   localparam int CMD_W     = 16;   // Q2.14 acceleration command
   localparam int TP_W      = 16;   // Q0.16 tick period
   localparam int VEL_W     = 19;   // velocity state, 2^-16 block/s
   localparam int VEL_UP_W  = 18;   // up-axis velocity on the result
   localparam int MAG_W     = 15;   // |command|, at most 1.0
   localparam int STEP_W    = 20;   // rounded acceleration step
   localparam int WIDE_W    = 23;   // working width for the velocity update
   localparam int PROD_W    = MAG_W + TP_W;
   localparam int SCALED_W  = 35;

   // fixed-point constants
   localparam int ACC_FRAC  = 14;
   localparam int VEL_FRAC  = 16;
   localparam logic signed [CMD_W-1:0] CMD_ONE = 16'sd16384;
   localparam logic [TP_W-1:0] TICK_RESET = 16'd3277;

   // item codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // per-axis tuning
   typedef struct packed {
      logic [3:0] accel_k;
      logic [4:0] drag_k;
      logic [4:0] brake_k;
      logic [1:0] max_speed;
   } axis_type;

   localparam axis_type FWD_AXIS   = '{accel_k: 4'd8,  drag_k: 5'd5, brake_k: 5'd16,
                                       max_speed: 2'd3};
   localparam axis_type RIGHT_AXIS = '{accel_k: 4'd5,  drag_k: 5'd5, brake_k: 5'd10,
                                       max_speed: 2'd2};
   localparam axis_type UP_AXIS    = '{accel_k: 4'd10, drag_k: 5'd5, brake_k: 5'd20,
                                       max_speed: 2'd1};

   // control into each lane
   typedef struct packed {
      logic load;     // accepted load item
      logic tick;     // accepted tick item
      logic csr_we;   // tick period write
   } lane_ctl_type;

   // what a lane hands to the merge stage
   typedef struct packed {
      logic signed [VEL_W-1:0] vel;       // velocity after the item
      logic                    rejected;  // command out of range
   } lane_out_type;

   // move v toward zero by s without crossing zero
   function automatic logic signed [WIDE_W-1:0] toward_zero(
      input logic signed [WIDE_W-1:0] v,
      input logic signed [WIDE_W-1:0] s
   );
      logic signed [WIDE_W-1:0] dn;
      logic signed [WIDE_W-1:0] up;
      logic signed [WIDE_W-1:0] res;
      dn  = v - s;
      up  = v + s;
      res = '0;
      if (v > 0) begin
         res = (dn > 0) ? dn : '0;
      end else if (v < 0) begin
         res = (up < 0) ? up : '0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* hdl/tvr_if.sv */
// ----------------------------------------------------------------------------
// tvr channels: valid/ready interfaces for the velocity ramp
// Request items, result items and the tick period write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvr_req_if;
   import tvr_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic signed [CMD_W-1:0] new_accel_fwd;
   logic signed [CMD_W-1:0] new_accel_right;
   logic signed [CMD_W-1:0] new_accel_up;

   modport source (output valid, cmd, new_accel_fwd, new_accel_right, new_accel_up,
                   input ready);
   modport sink   (input valid, cmd, new_accel_fwd, new_accel_right, new_accel_up,
                   output ready);
endinterface

interface tvr_rsp_if;
   import tvr_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VEL_W-1:0]    out_vel_fwd;
   logic signed [VEL_W-1:0]    out_vel_right;
   logic signed [VEL_UP_W-1:0] out_vel_up;
   logic                       moving;
   logic [2:0]                 rejected_mask;

   modport source (output valid, out_vel_fwd, out_vel_right, out_vel_up, moving,
                   rejected_mask, input ready);
   modport sink   (input valid, out_vel_fwd, out_vel_right, out_vel_up, moving,
                   rejected_mask, output ready);
endinterface

interface tvr_csr_if;
   import tvr_pkg::*;
   logic            valid;
   logic            ready;
   logic [TP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/three_axis_velocity_ramp_top.sv */
// ----------------------------------------------------------------------------
// three_axis_velocity_ramp_top: three-axis velocity ramp with drag and brake
// Forward, right and up axes run as parallel lanes; a merge stage forms the
// result item.
// ----------------------------------------------------------------------------
// Usage
//  req_ch: one item per handshake. cmd = load replaces the three Q2.14
//    commands (out-of-range ones are dropped and flagged); cmd = tick
//    advances every axis one tick period.
//  rsp_ch: one result item per request item, in order: the velocities after
//    the item, moving, and the rejected-command mask (zero on ticks).
//  csr_ch: writes tick_period (Q0.16 seconds); always ready. Write only while
//    no item is in flight.
//  Result: the result item is registered and valid in the cycle after the request is accepted.
//  Throughput: one item per cycle while results are taken. Each lane
//    forms its next velocity combinationally from registered state; the
//    acceleration step is kept in a per-lane register alongside the command.
//  Stall: while the result register holds an item the receiver has not
//    taken, req_ch.ready is low; nothing is dropped.
//  Reset: tick_period returns to 3277, commands and velocities to zero, and
//    the result register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module three_axis_velocity_ramp_top (
   input  logic      clock,
   input  logic      reset,
   tvr_req_if.sink   req_ch,
   tvr_rsp_if.source rsp_ch,
   tvr_csr_if.sink   csr_ch
);
   import tvr_pkg::*;

   logic [TP_W-1:0] tick_period_ff, tick_period_in;
   logic            room;
   logic            accept;
   lane_ctl_type    ctl;
   lane_out_type    fwd_out, right_out, up_out;

   // handshakes
   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;
   assign csr_ch.ready = 1'b1;

   assign ctl.load   = accept && (req_ch.cmd == CMD_LOAD);
   assign ctl.tick   = accept && (req_ch.cmd == CMD_TICK);
   assign ctl.csr_we = csr_ch.valid;

   // tick period register
   assign tick_period_in = csr_ch.valid ? csr_ch.data : tick_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_RESET;
      end else begin
         tick_period_ff <= tick_period_in;
      end
   end

   // axis lanes
   tvr_lane #(.AXIS(FWD_AXIS)) u_lane_fwd (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .tick_period (tick_period_ff),
      .csr_data    (csr_ch.data),
      .new_accel   (req_ch.new_accel_fwd),
      .result      (fwd_out)
   );

   tvr_lane #(.AXIS(RIGHT_AXIS)) u_lane_right (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .tick_period (tick_period_ff),
      .csr_data    (csr_ch.data),
      .new_accel   (req_ch.new_accel_right),
      .result      (right_out)
   );

   tvr_lane #(.AXIS(UP_AXIS)) u_lane_up (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .tick_period (tick_period_ff),
      .csr_data    (csr_ch.data),
      .new_accel   (req_ch.new_accel_up),
      .result      (up_out)
   );

   // merge and output register
   tvr_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .fwd    (fwd_out),
      .right  (right_out),
      .up     (up_out),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

/* hdl/tvr_lane.sv */
// ----------------------------------------------------------------------------
// tvr_lane: one axis of the velocity ramp
// Holds the axis command, velocity and precomputed acceleration step, and
// applies drag, brake or acceleration on each tick item.
// ----------------------------------------------------------------------------
`default_nettype none

module tvr_lane #(
   parameter tvr_pkg::axis_type AXIS = tvr_pkg::FWD_AXIS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tvr_pkg::lane_ctl_type                ctl,
   input  logic [tvr_pkg::TP_W-1:0]             tick_period,
   input  logic [tvr_pkg::TP_W-1:0]             csr_data,
   input  logic signed [tvr_pkg::CMD_W-1:0]     new_accel,
   output tvr_pkg::lane_out_type                result
);
   import tvr_pkg::*;

   localparam logic signed [WIDE_W-1:0] VEL_LIM = WIDE_W'(AXIS.max_speed) << VEL_FRAC;

   logic signed [CMD_W-1:0]  accel_ff, accel_in;
   logic signed [VEL_W-1:0]  vel_ff, vel_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   logic                     in_range;
   logic signed [CMD_W-1:0]  neg_new, neg_cur;
   logic [MAG_W-1:0]         mag_new, mag_cur, mul_mag;
   logic [TP_W-1:0]          mul_tp;
   logic [PROD_W-1:0]        prod;
   logic [SCALED_W-1:0]      scaled, rounded;

   logic signed [WIDE_W-1:0] vx, step_s, drag_step, brake_step, vel_sum, vel_tick;
   logic                     clear_cmd;

   // command range check and magnitudes
   assign in_range = (new_accel >= -CMD_ONE) && (new_accel <= CMD_ONE);
   assign neg_new  = -new_accel;
   assign neg_cur  = -accel_ff;
   assign mag_new  = new_accel[CMD_W-1] ? neg_new[MAG_W-1:0] : new_accel[MAG_W-1:0];
   assign mag_cur  = accel_ff[CMD_W-1] ? neg_cur[MAG_W-1:0] : accel_ff[MAG_W-1:0];

   // step = round(|cmd| * k * tick_period) in velocity units, kept in step with
   // the command and tick period registers so a tick uses it directly
   assign mul_mag = (ctl.load && in_range) ? mag_new : mag_cur;
   assign mul_tp  = ctl.csr_we ? csr_data : tick_period;
   assign prod    = PROD_W'(mul_mag) * PROD_W'(mul_tp);
   assign scaled  = SCALED_W'(prod) * SCALED_W'(AXIS.accel_k);
   assign rounded = scaled + (SCALED_W'(1) << (ACC_FRAC - 1));
   assign step_in = STEP_W'(rounded >> ACC_FRAC);

   // drag and brake steps are exact
   assign vx         = WIDE_W'(vel_ff);
   assign step_s     = WIDE_W'(step_ff);
   assign drag_step  = WIDE_W'(tick_period) * WIDE_W'(AXIS.drag_k);
   assign brake_step = WIDE_W'(tick_period) * WIDE_W'(AXIS.brake_k);
   assign vel_sum    = accel_ff[CMD_W-1] ? (vx - step_s) : (vx + step_s);

   // tick update: drag, brake or accelerate with clamp
   always_comb begin
      vel_tick  = vx;
      clear_cmd = 1'b0;
      if (accel_ff == '0) begin
         vel_tick = toward_zero(vx, drag_step);
      end else if ((vel_ff != '0) && ((vel_ff > 0) != (accel_ff > 0))) begin
         vel_tick  = toward_zero(vx, brake_step);
         clear_cmd = (vel_tick == '0);
      end else if (vel_sum > VEL_LIM) begin
         vel_tick = VEL_LIM;
      end else if (vel_sum < -VEL_LIM) begin
         vel_tick = -VEL_LIM;
      end else begin
         vel_tick = vel_sum;
      end
   end

   // next state
   always_comb begin
      accel_in = accel_ff;
      vel_in   = vel_ff;
      if (ctl.load && in_range) begin
         accel_in = new_accel;
      end else if (ctl.tick) begin
         vel_in = VEL_W'(vel_tick);
         if (clear_cmd) begin
            accel_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff <= '0;
         vel_ff   <= '0;
      end else begin
         accel_ff <= accel_in;
         vel_ff   <= vel_in;
      end
   end

   // step only matters while the command is nonzero
   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign result.vel      = vel_in;
   assign result.rejected = ctl.load && !in_range;

   // drag never carries the velocity across zero
   a_drag_no_cross: assert property (@(posedge clock) disable iff (reset)
      (ctl.tick && accel_ff == '0) |=>
      ((vel_ff == '0) || (($past(vel_ff) > 0) == (vel_ff > 0))))
      else $error("drag crossed zero");

   // a rejected command leaves the stored command alone
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (ctl.load && !in_range) |=> $stable(accel_ff))
      else $error("rejected command changed state");

   // velocity stays inside the axis speed limit
   a_vel_limit: assert property (@(posedge clock) disable iff (reset)
      (vx <= VEL_LIM) && (vx >= -VEL_LIM))
      else $error("velocity beyond axis limit");

endmodule

`default_nettype wire

/* hdl/tvr_merge.sv */
// ----------------------------------------------------------------------------
// tvr_merge: combines the three lanes into one result item
// Builds moving and rejected_mask and holds the result in an output register
// that frees itself when the receiver takes the item.
// ----------------------------------------------------------------------------
`default_nettype none

module tvr_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  tvr_pkg::lane_out_type fwd,
   input  tvr_pkg::lane_out_type right,
   input  tvr_pkg::lane_out_type up,
   output logic                  room,
   tvr_rsp_if.source             rsp_ch
);
   import tvr_pkg::*;

   logic                       out_valid_ff, out_valid_in;
   logic signed [VEL_W-1:0]    vel_fwd_ff, vel_right_ff;
   logic signed [VEL_UP_W-1:0] vel_up_ff;
   logic                       moving_ff;
   logic [2:0]                 mask_ff;

   // output register is free when empty or being drained
   assign room         = !out_valid_ff || rsp_ch.ready;
   assign out_valid_in = accept || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // capture the merged item
   always_ff @(posedge clock) begin
      if (accept) begin
         vel_fwd_ff   <= fwd.vel;
         vel_right_ff <= right.vel;
         vel_up_ff    <= up.vel[VEL_UP_W-1:0];
         moving_ff    <= (fwd.vel != '0) || (right.vel != '0) || (up.vel != '0);
         mask_ff      <= {up.rejected, right.rejected, fwd.rejected};
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_vel_fwd   = vel_fwd_ff;
   assign rsp_ch.out_vel_right = vel_right_ff;
   assign rsp_ch.out_vel_up    = vel_up_ff;
   assign rsp_ch.moving        = moving_ff;
   assign rsp_ch.rejected_mask = mask_ff;

   // output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("result valid after reset");

   // an accepted item always lands in the output register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted item lost");

   // moving agrees with the held forward and right velocities
   a_moving: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (vel_fwd_ff != '0 || vel_right_ff != '0)) |-> moving_ff)
      else $error("moving flag inconsistent");

endmodule

`default_nettype wire
